@@ hw/rtl/least_laxity_tick_scheduler_assert.svh @@
// Assertion macros used by the scheduler core RTL.
`ifndef LEAST_LAXITY_TICK_SCHEDULER_ASSERT_SVH
`define LEAST_LAXITY_TICK_SCHEDULER_ASSERT_SVH

`define LLTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LLTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/llts_pkg.sv @@
// Shared types and constants of the least-laxity tick scheduler.
package llts_pkg;

    localparam int MAX_TASKS_DEF  = 4;
    localparam int TIME_BITS_DEF  = 16;

    localparam int ACTIVE_BITS    = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int FIELD_BITS     = 16;
    localparam int TASK_IDX_BITS  = 3;
    localparam int OUT_IDX_BITS   = 2;
    localparam int MASK_BITS      = 4;

    localparam logic [ACTIVE_BITS-1:0]    ACTIVE_RESET = 3'd1;
    localparam logic [CFG_DATA_BITS-1:0]  TIMING_RESET = 32'h0001_0001;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE   = 3'd0;

    typedef struct packed {
        logic                     found;
        logic [TASK_IDX_BITS-1:0] idx;
    } sel_t;

endpackage

@@ hw/rtl/llts_cfg.sv @@
// Configuration registers: active task count and per-task timing words.
module llts_cfg #(
    parameter int MAX_TASKS = llts_pkg::MAX_TASKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [llts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [llts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output logic [llts_pkg::ACTIVE_BITS-1:0]    active_tasks,
    output logic [MAX_TASKS-1:0][llts_pkg::CFG_DATA_BITS-1:0] timing
);
    import llts_pkg::*;

    logic [ACTIVE_BITS-1:0]                  active_reg;
    logic [MAX_TASKS-1:0][CFG_DATA_BITS-1:0] timing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                timing_reg[i] <= TIMING_RESET;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_ACTIVE)
            begin
                active_reg <= cfg_data[ACTIVE_BITS-1:0];
            end
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                if (cfg_index == CFG_INDEX_BITS'(i + 1))
                begin
                    timing_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign active_tasks = active_reg;
    assign timing       = timing_reg;

endmodule

@@ hw/rtl/llts_select.sv @@
// Least-laxity pick over the eligible tasks, lowest index on ties.
module llts_select #(
    parameter int MAX_TASKS = llts_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = llts_pkg::TIME_BITS_DEF
) (
    input  logic [MAX_TASKS-1:0]                eligible,
    input  logic [MAX_TASKS-1:0][TIME_BITS:0]   laxity,
    output llts_pkg::sel_t                      sel
);
    import llts_pkg::*;

    always_comb
    begin
        logic [TIME_BITS:0] best;
        sel_t               pick;
        best = '0;
        pick = '0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if (eligible[i] && (!pick.found || $signed(laxity[i]) < $signed(best)))
            begin
                pick.found = 1'b1;
                pick.idx   = TASK_IDX_BITS'(i);
                best       = laxity[i];
            end
        end
        sel = pick;
    end

endmodule

@@ hw/rtl/llts_core.sv @@
// Tick register, per-task scheduling state, slot decision and result register.
`include "least_laxity_tick_scheduler_assert.svh"
module llts_core #(
    parameter int MAX_TASKS = llts_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = llts_pkg::TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                task_valid,
    output logic [llts_pkg::OUT_IDX_BITS-1:0]   task_index,
    output logic                                deadline_miss,
    output logic [llts_pkg::MASK_BITS-1:0]      miss_mask,
    output logic                                halted,
    input  logic [llts_pkg::ACTIVE_BITS-1:0]    active_tasks,
    input  logic [MAX_TASKS-1:0][llts_pkg::CFG_DATA_BITS-1:0] timing
);
    import llts_pkg::*;

    localparam int LW = TIME_BITS + 1;
    localparam int CW = (TIME_BITS + 2 > 18) ? TIME_BITS + 2 : 18;
    localparam logic signed [CW-1:0] LAX_MAX_C = CW'((64'd1 << TIME_BITS) - 64'd1);
    localparam logic signed [CW-1:0] LAX_MIN_C = ~LAX_MAX_C;
    localparam logic [LW-1:0]        LAX_MIN_S = {1'b1, {TIME_BITS{1'b0}}};

    logic                   s1_valid_reg;
    logic                   s1_restart_reg;
    logic                   advance;

    logic [MAX_TASKS-1:0][TIME_BITS-1:0] phase_reg, phase_next;
    logic [MAX_TASKS-1:0][TIME_BITS-1:0] work_reg, work_next;
    logic [MAX_TASKS-1:0][LW-1:0]        lax_reg, lax_next;
    logic [MAX_TASKS-1:0]                inf_reg, inf_next;
    logic                                stopped_reg, stopped_next;

    logic                                res_valid_reg;
    logic                                res_task_valid_reg;
    logic [OUT_IDX_BITS-1:0]             res_index_reg;
    logic                                res_miss_reg;
    logic [MASK_BITS-1:0]                res_mask_reg;
    logic                                res_halted_reg;

    logic                                stop_eff;
    logic [MAX_TASKS-1:0]                miss;
    logic [MAX_TASKS-1:0]                eligible;
    logic [MAX_TASKS-1:0][LW-1:0]        lax_rel;
    logic                                any_miss;
    sel_t                                sel;
    logic [MAX_TASKS+MASK_BITS-1:0]      mask_ext;

    assign advance  = s1_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign stop_eff = stopped_reg && !s1_restart_reg;
    assign any_miss = |miss;
    assign mask_ext = {{MASK_BITS{1'b0}}, miss};

    for (genvar g = 0; g < MAX_TASKS; g++)
    begin : g_task
        logic                              act;
        logic [TIME_BITS-1:0]              ph, wl, ph1, wl1, wl2;
        logic [LW-1:0]                     lx1, lx2;
        logic                              inf, inf1, inf2;
        logic                              rel, load, is_run;
        logic [FIELD_BITS-1:0]             pm1;
        logic [TIME_BITS+FIELD_BITS-1:0]   pm1_ext, exec_ext;
        logic [FIELD_BITS:0]               period;
        logic signed [CW-1:0]              diff, lax_clamp;

        assign act  = TASK_IDX_BITS'(g) < active_tasks;
        assign ph   = s1_restart_reg ? '0 : phase_reg[g];
        assign wl   = s1_restart_reg ? '0 : work_reg[g];
        assign inf  = s1_restart_reg ? 1'b0 : inf_reg[g];
        assign rel  = act && (ph == '0);
        assign load = rel && (wl == '0);

        assign pm1      = timing[g][FIELD_BITS-1:0] - FIELD_BITS'(1);
        assign pm1_ext  = {{TIME_BITS{1'b0}}, pm1};
        assign exec_ext = {{TIME_BITS{1'b0}}, timing[g][2*FIELD_BITS-1:FIELD_BITS]};
        assign period   = (timing[g][FIELD_BITS-1:0] == '0) ?
                          {1'b1, {FIELD_BITS{1'b0}}} : {1'b0, timing[g][FIELD_BITS-1:0]};
        assign diff     = $signed({{(CW-FIELD_BITS-1){1'b0}}, period})
                        - $signed({{(CW-FIELD_BITS){1'b0}},
                                   timing[g][2*FIELD_BITS-1:FIELD_BITS]});
        assign lax_clamp = (diff > LAX_MAX_C) ? LAX_MAX_C :
                           (diff < LAX_MIN_C) ? LAX_MIN_C : diff;

        assign ph1  = !act ? ph : (rel ? pm1_ext[TIME_BITS-1:0] : ph - TIME_BITS'(1));
        assign wl1  = load ? exec_ext[TIME_BITS-1:0] : wl;
        assign lx1  = load ? lax_clamp[LW-1:0] : lax_reg[g];
        assign inf1 = load ? 1'b0 : inf;

        assign miss[g]     = rel && (wl != '0);
        assign eligible[g] = act && (wl1 != '0) && !inf1;
        assign lax_rel[g]  = lx1;

        assign is_run = sel.found && (sel.idx == TASK_IDX_BITS'(g));
        assign wl2    = is_run ? wl1 - TIME_BITS'(1) : wl1;

        always_comb
        begin
            lx2  = lx1;
            inf2 = inf1;
            if (act)
            begin
                if (wl2 == '0)
                begin
                    inf2 = 1'b1;
                end
                else if (!is_run && lx1 != LAX_MIN_S)
                begin
                    lx2 = lx1 - LW'(1);
                end
            end
        end

        assign phase_next[g] = stop_eff ? ph : ph1;
        assign work_next[g]  = stop_eff ? wl : (any_miss ? wl1 : wl2);
        assign lax_next[g]   = stop_eff ? lax_reg[g] : (any_miss ? lx1 : lx2);
        assign inf_next[g]   = stop_eff ? inf : (any_miss ? inf1 : inf2);
    end

    llts_select #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_select (
        .eligible (eligible),
        .laxity   (lax_rel),
        .sel      (sel)
    );

    assign stopped_next = stop_eff || any_miss;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_restart_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg   <= 1'b1;
            s1_restart_reg <= restart;
        end
        else if (advance)
        begin
            s1_valid_reg   <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            work_reg    <= '0;
            inf_reg     <= '0;
            stopped_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            work_reg    <= work_next;
            inf_reg     <= inf_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lax_reg <= lax_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_task_valid_reg <= !stop_eff && !any_miss && sel.found;
            res_index_reg      <= (!stop_eff && !any_miss && sel.found) ?
                                  sel.idx[OUT_IDX_BITS-1:0] : '0;
            res_miss_reg       <= !stop_eff && any_miss;
            res_mask_reg       <= stop_eff ? '0 : mask_ext[MASK_BITS-1:0];
            res_halted_reg     <= stopped_next;
        end
    end

    assign out_valid     = res_valid_reg;
    assign task_valid    = res_task_valid_reg;
    assign task_index    = res_index_reg;
    assign deadline_miss = res_miss_reg;
    assign miss_mask     = res_mask_reg;
    assign halted        = res_halted_reg;

    `LLTS_ASSERT_SAME(a_run_not_halted, clk, rst_n,
        res_valid_reg && res_task_valid_reg, !res_miss_reg && !res_halted_reg,
        "task runs in a halted or missed slot")
    `LLTS_ASSERT_SAME(a_miss_halts, clk, rst_n,
        res_valid_reg && res_miss_reg, res_halted_reg && stopped_reg,
        "deadline miss without halt")
    `LLTS_ASSERT_SAME(a_idle_index_zero, clk, rst_n,
        res_valid_reg && !res_task_valid_reg, res_index_reg == '0,
        "idle slot with nonzero task index")
    `LLTS_ASSERT_NEXT(a_halt_freezes, clk, rst_n,
        advance && stopped_reg && !s1_restart_reg,
        $stable(phase_reg) && $stable(work_reg) && stopped_reg,
        "state changed while halted")

endmodule

@@ hw/rtl/least_laxity_tick_scheduler.sv @@
// Least-laxity-first tick scheduler top level.
// Flow: an accepted tick beat is held in the input register; its slot result is then registered in the result register.
// Throughput: one tick per cycle while results are taken; the slot decision is a single pass through the state.
// Backpressure: while a result waits, one more tick is held in the input register, then stall.
// Reset: asynchronous active low; task phase, work and done flags and halt clear, config returns to defaults.
module least_laxity_tick_scheduler #(
    parameter int MAX_TASKS = llts_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = llts_pkg::TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [llts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [llts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                task_valid,
    output logic [llts_pkg::OUT_IDX_BITS-1:0]   task_index,
    output logic                                deadline_miss,
    output logic [llts_pkg::MASK_BITS-1:0]      miss_mask,
    output logic                                halted
);
    import llts_pkg::*;

    logic [ACTIVE_BITS-1:0]                  active_tasks;
    logic [MAX_TASKS-1:0][CFG_DATA_BITS-1:0] timing;

    llts_cfg #(
        .MAX_TASKS (MAX_TASKS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .active_tasks (active_tasks),
        .timing       (timing)
    );

    llts_core #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .task_valid    (task_valid),
        .task_index    (task_index),
        .deadline_miss (deadline_miss),
        .miss_mask     (miss_mask),
        .halted        (halted),
        .active_tasks  (active_tasks),
        .timing        (timing)
    );

endmodule

@@ tb/tb_least_laxity_tick_scheduler.sv @@
// Self-checking testbench for the least-laxity tick scheduler: ticks in, one slot decision out.
module tb_least_laxity_tick_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import llts_pkg::*;

    localparam int MAX_TASKS   = MAX_TASKS_DEF;
    localparam int LAX_MIN     = -65536;
    localparam int LAX_MAX     = 65535;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 12;
    localparam int PHASE_TICKS = 52;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TIMING_BASE  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_FIRST = 3'd5;

    typedef enum logic [1:0] {MODE_RX_SLOW, MODE_TX_SLOW, MODE_FREE} idle_mode_t;

    typedef struct packed {
        logic                    task_valid;
        logic [OUT_IDX_BITS-1:0] task_index;
        logic                    deadline_miss;
        logic [MASK_BITS-1:0]    miss_mask;
        logic                    halted;
    } slot_t;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic                      restart   = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      task_valid;
    logic [OUT_IDX_BITS-1:0]   task_index;
    logic                      deadline_miss;
    logic [MASK_BITS-1:0]      miss_mask;
    logic                      halted;

    // Scheduler image: registers and per-task state.
    logic [ACTIVE_BITS-1:0]   active_cnt;
    logic [31:0]              timing_reg [MAX_TASKS];
    logic [15:0]              phase_cnt  [MAX_TASKS];
    logic [15:0]              work_rem   [MAX_TASKS];
    logic signed [16:0]       lax_val    [MAX_TASKS];
    logic                     lax_inf    [MAX_TASKS];
    logic                     sched_stopped;

    bit         tick_backlog [$];
    slot_t      pending_slots [$];
    slot_t      want_slot;
    idle_mode_t idle_mode = MODE_RX_SLOW;
    int         fail_count = 0;
    int         cycle_count = 0;

    least_laxity_tick_scheduler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .task_valid   (task_valid),
        .task_index   (task_index),
        .deadline_miss(deadline_miss),
        .miss_mask    (miss_mask),
        .halted       (halted)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_schedule();
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            phase_cnt[i] = '0;
            work_rem[i]  = '0;
            lax_val[i]   = '0;
            lax_inf[i]   = 1'b0;
        end
        sched_stopped = 1'b0;
    endfunction

    function automatic slot_t schedule_slot(logic rst_tick);
        slot_t              r;
        int                 n;
        int                 run;
        int                 lax;
        logic [16:0]        period;
        logic [15:0]        exec_t;
        logic [3:0]         missed;
        logic signed [16:0] best;
        r      = '0;
        missed = '0;
        run    = -1;
        best   = '0;
        if (rst_tick)
            clear_schedule();
        if (sched_stopped)
        begin
            r.halted = 1'b1;
            return r;
        end
        n = (active_cnt > MAX_TASKS) ? MAX_TASKS : int'(active_cnt);
        for (int i = 0; i < n; i++)
        begin
            if (phase_cnt[i] == 0)
            begin
                period = {1'b0, timing_reg[i][15:0]};
                if (period == 0)
                    period = 17'h10000;
                exec_t = timing_reg[i][31:16];
                phase_cnt[i] = 16'(period - 17'd1);
                if (work_rem[i] != 0)
                    missed[i] = 1'b1;
                else
                begin
                    work_rem[i] = exec_t;
                    lax = int'(period) - int'(exec_t);
                    if (lax > LAX_MAX)
                        lax = LAX_MAX;
                    if (lax < LAX_MIN)
                        lax = LAX_MIN;
                    lax_val[i] = 17'(lax);
                    lax_inf[i] = 1'b0;
                end
            end
            else
                phase_cnt[i] = phase_cnt[i] - 16'd1;
        end
        if (missed != 0)
        begin
            sched_stopped   = 1'b1;
            r.deadline_miss = 1'b1;
            r.miss_mask     = missed;
            r.halted        = 1'b1;
            return r;
        end
        for (int i = 0; i < n; i++)
        begin
            if (work_rem[i] != 0 && !lax_inf[i] && (run < 0 || lax_val[i] < best))
            begin
                run  = i;
                best = lax_val[i];
            end
        end
        if (run >= 0)
        begin
            work_rem[run] = work_rem[run] - 16'd1;
            r.task_valid  = 1'b1;
            r.task_index  = OUT_IDX_BITS'(run);
        end
        for (int i = 0; i < n; i++)
        begin
            if (work_rem[i] == 0)
                lax_inf[i] = 1'b1;
            else if (i != run && int'(lax_val[i]) > LAX_MIN)
                lax_val[i] = lax_val[i] - 17'sd1;
        end
        return r;
    endfunction

    function automatic bit sender_gap();
        case (idle_mode)
            MODE_RX_SLOW: return $urandom_range(0, 99) < 20;
            MODE_TX_SLOW: return $urandom_range(0, 99) < 77;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            MODE_RX_SLOW: return $urandom_range(0, 99) < 77;
            MODE_TX_SLOW: return $urandom_range(0, 99) < 20;
            default:      return 1'b0;
        endcase
    endfunction

    // Driver: advance the tick backlog, hold a beat until taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            restart  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_slots.push_back(schedule_slot(restart));
            if (!in_valid || in_ready)
            begin
                if (tick_backlog.size() != 0 && !sender_gap())
                begin
                    in_valid <= 1'b1;
                    restart  <= tick_backlog.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                    restart  <= 1'($urandom_range(0, 1));
                end
            end
        end
    end

    task automatic check_field(string field, int want, int got);
        if (want != got)
        begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Monitor: compare each result beat against the oldest predicted slot.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_slots.size() == 0)
                begin
                    $display("%0t unexpected result beat: expected none actual %0h", $time,
                             {task_valid, task_index, deadline_miss, miss_mask, halted});
                    fail_count++;
                end
                else
                begin
                    want_slot = pending_slots.pop_front();
                    check_field("task_valid", want_slot.task_valid, task_valid);
                    check_field("task_index", want_slot.task_index, task_index);
                    check_field("deadline_miss", want_slot.deadline_miss, deadline_miss);
                    check_field("miss_mask", want_slot.miss_mask, miss_mask);
                    check_field("halted", want_slot.halted, halted);
                end
            end
            out_ready <= !receiver_stall();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d results outstanding", $time, pending_slots.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_ACTIVE)
            active_cnt = val[ACTIVE_BITS-1:0];
        else if (idx < REG_UNUSED_FIRST)
            timing_reg[idx - REG_TIMING_BASE] = val;
    endtask

    task automatic program_schedule(logic [31:0] act_word, logic [31:0] t0, logic [31:0] t1,
                                    logic [31:0] t2, logic [31:0] t3);
        write_reg(REG_ACTIVE, act_word);
        write_reg(REG_TIMING_BASE, t0);
        write_reg(REG_TIMING_BASE + 3'd1, t1);
        write_reg(REG_TIMING_BASE + 3'd2, t2);
        write_reg(REG_TIMING_BASE + 3'd3, t3);
    endtask

    task automatic queue_ticks(int count, bit lead_restart, int restart_odds);
        for (int i = 0; i < count; i++)
        begin
            if (i == 0)
                tick_backlog.push_back(lead_restart);
            else if (restart_odds == 0)
                tick_backlog.push_back(1'b0);
            else
                tick_backlog.push_back($urandom_range(1, restart_odds) == 1);
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (tick_backlog.size() != 0 || in_valid || pending_slots.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_timing();
        int          pick;
        logic [15:0] period;
        pick   = $urandom_range(0, 9);
        period = 16'($urandom_range(2, 16));
        if (pick == 0)
            return $urandom();
        if (pick == 1)
            return {16'd0, period};
        return {16'($urandom_range(1, period / 2)), period};
    endfunction

    function automatic logic [31:0] rand_active();
        logic [ACTIVE_BITS-1:0] cnt;
        cnt = ACTIVE_BITS'($urandom_range(0, 7));
        if ($urandom_range(0, 3) != 0)
            cnt = ACTIVE_BITS'($urandom_range(1, MAX_TASKS));
        return {29'($urandom()), cnt};
    endfunction

    initial
    begin
        int ph;
        active_cnt = ACTIVE_RESET;
        for (int i = 0; i < MAX_TASKS; i++)
            timing_reg[i] = TIMING_RESET;
        clear_schedule();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: defaults, a mixed set with zero execution, a miss and halt,
        // the widest periods, and out-of-range active counts.
        queue_ticks(4, 1'b0, 0);
        wait_idle();
        program_schedule({29'h1555_5555, 3'd3}, {16'd1, 16'd4}, {16'd2, 16'd6},
                         {16'd0, 16'd5}, {16'hFFFF, 16'h0000});
        queue_ticks(10, 1'b1, 0);
        wait_idle();
        write_reg(REG_TIMING_BASE, {16'd3, 16'd2});
        queue_ticks(4, 1'b1, 0);
        queue_ticks(1, 1'b1, 0);
        wait_idle();
        program_schedule({29'h0AAA_AAAA, 3'd7}, {16'hFFFF, 16'h0000}, {16'h0000, 16'h0000},
                         {16'd1, 16'd1}, {16'd0, 16'd1});
        queue_ticks(4, 1'b1, 0);
        wait_idle();
        write_reg(REG_ACTIVE, 32'hFFFF_FFF8);
        write_reg(REG_UNUSED_FIRST, 32'hFFFF_FFFF);
        queue_ticks(2, 1'b0, 0);
        wait_idle();

        for (ph = 0; ph < PHASES; ph++)
        begin
            idle_mode = (ph < PHASES / 3) ? MODE_RX_SLOW :
                        (ph < 2 * PHASES / 3) ? MODE_TX_SLOW : MODE_FREE;
            program_schedule(rand_active(), rand_timing(), rand_timing(), rand_timing(),
                             rand_timing());
            if (ph % 4 == 0)
                write_reg(REG_UNUSED_FIRST + 3'($urandom_range(0, 2)), $urandom());
            queue_ticks(PHASE_TICKS / 2, 1'b1, 40);
            if (ph % 3 == 1)
                wait_idle();
            queue_ticks(PHASE_TICKS / 2, 1'b0, 40);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
